// ===== src/seq_tagged_lru_poll_cache_top_macros.svh =====
// Assertion macros shared by the cache checker.
`ifndef SEQ_TAGGED_LRU_POLL_CACHE_TOP_MACROS_SVH
`define SEQ_TAGGED_LRU_POLL_CACHE_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SLPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SLPC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/slpc_pkg.sv =====
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants of the sequence-tagged LRU poll cache.
// ----------------------------------------------------------------------------
package slpc_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W   = 32;
	localparam int STAMP_W = 64;
	localparam int AGE_W   = 32;

	// leaves of the least-age tree
	localparam int NP      = 1 << IDX_W;

	// two-slot request and result queues
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;
	localparam logic [QCNT_W-1:0] QDEPTH = 2'd2;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_RECORD = 1'b1
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] window;
		logic [KEY_W-1:0] first_msg;
		logic [KEY_W-1:0] last_msg;
		logic [KEY_W-1:0] wake_mask;
		logic [KEY_W-1:0] peek_flags;
		logic [KEY_W-1:0] internal_flag;
	} key_t;

	typedef struct packed {
		op_t                op;
		key_t               key;
		logic [STAMP_W-1:0] stamp;
	} req_t;

endpackage

// ===== src/seq_tagged_lru_poll_cache_top.sv =====
// ----------------------------------------------------------------------------
// seq_tagged_lru_poll_cache_top
// Fully associative LRU cache of filter keys tagged with sequence stamps.
// ----------------------------------------------------------------------------
// Input channel: drive the request fields and raise push; a request is taken
// at a rising edge with push high and full low. func 0 is a lookup, func 1
// records the key with its stamp. Result channel: while empty is low, hit
// shows the oldest result; raise pop to take it. Every request gives exactly
// one result, in request order. hit is 1 only for a lookup that finds its
// key with an equal stamp.
// A taken request waits in the request queue, is compared in the engine,
// is held in the second-stage registers and then writes its result into
// the result queue once that queue has room. The engine compares against
// all entries, registers the compare results and writes the entry state
// back from them; the following request is compared only after that writeback.
// Reset clears all valid bits, the age counter and both queues. A stalled
// result side holds results in a two-slot queue; once it fills the engine
// stops, the two-slot request queue fills, and full rises.
// ----------------------------------------------------------------------------
module seq_tagged_lru_poll_cache_top
	import slpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [KEY_W-1:0]   window,
	input  logic [KEY_W-1:0]   first_msg,
	input  logic [KEY_W-1:0]   last_msg,
	input  logic [KEY_W-1:0]   wake_mask,
	input  logic [KEY_W-1:0]   peek_flags,
	input  logic [KEY_W-1:0]   internal_flag,
	input  logic [STAMP_W-1:0] stamp,
	output logic               empty,
	input  logic               pop,
	output logic               hit
);

	logic req_valid;
	logic req_take;
	req_t req;

	slpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.window        (window),
		.first_msg     (first_msg),
		.last_msg      (last_msg),
		.wake_mask     (wake_mask),
		.peek_flags    (peek_flags),
		.internal_flag (internal_flag),
		.stamp         (stamp),
		.req_valid     (req_valid),
		.req           (req),
		.req_take      (req_take)
	);

	slpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take),
		.empty     (empty),
		.pop       (pop),
		.hit       (hit)
	);

endmodule

// ===== src/slpc_front.sv =====
// ----------------------------------------------------------------------------
// slpc_front
// Accepts input requests, decodes the operation and holds them in a
// two-slot queue until the cache engine takes them.
// ----------------------------------------------------------------------------
module slpc_front
	import slpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [KEY_W-1:0]   window,
	input  logic [KEY_W-1:0]   first_msg,
	input  logic [KEY_W-1:0]   last_msg,
	input  logic [KEY_W-1:0]   wake_mask,
	input  logic [KEY_W-1:0]   peek_flags,
	input  logic [KEY_W-1:0]   internal_flag,
	input  logic [STAMP_W-1:0] stamp,
	output logic               req_valid,
	output req_t               req,
	input  logic               req_take
);

	req_t              slot_q [2];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;
	logic              rd_en;
	req_t              req_in;

	always_comb begin
		req_in.op                = op_t'(func);
		req_in.key.window        = window;
		req_in.key.first_msg     = first_msg;
		req_in.key.last_msg      = last_msg;
		req_in.key.wake_mask     = wake_mask;
		req_in.key.peek_flags    = peek_flags;
		req_in.key.internal_flag = internal_flag;
		req_in.stamp             = stamp;
	end

	assign full      = (cnt_q == QDEPTH);
	assign req_valid = (cnt_q != '0);
	assign req       = slot_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = req_take && req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= req_in;
		end
	end

endmodule

// ===== src/slpc_back.sv =====
// ----------------------------------------------------------------------------
// slpc_back
// Cache engine: compares a request against all entries and picks the LRU
// candidate in stage 1, resolves and writes back in stage 2 once the result
// queue has room, and queues the hit flag for the result port.
// ----------------------------------------------------------------------------
module slpc_back
	import slpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_take,
	output logic empty,
	input  logic pop,
	output logic hit
);

	// entry store
	key_t               key_q   [ENTRIES];
	logic [STAMP_W-1:0] stamp_q [ENTRIES];
	logic [AGE_W-1:0]   age_q   [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]   age_cnt_q;

	// second stage
	logic               v_s2;
	op_t                op_s2;
	key_t               key_s2;
	logic [STAMP_W-1:0] stamp_s2;
	logic [ENTRIES-1:0] match_s2;
	logic [ENTRIES-1:0] steq_s2;
	logic [ENTRIES-1:0] inv_s2;
	logic [IDX_W-1:0]   lru_s2;

	// result queue
	logic               res_q [2];
	logic [QPTR_W-1:0]  res_wr_q;
	logic [QPTR_W-1:0]  res_rd_q;
	logic [QCNT_W-1:0]  res_cnt_q;
	logic               res_full;
	logic               res_pop;

	logic [ENTRIES-1:0] match_d;
	logic [ENTRIES-1:0] steq_d;
	logic [AGE_W-1:0]   t_age  [2*NP];
	logic [IDX_W-1:0]   t_idx  [2*NP];
	logic               t_real [2*NP];
	logic               take_r;

	logic               done_s2;
	logic               lk_found;
	logic [IDX_W-1:0]   lk_idx;
	logic               rec_found;
	logic [IDX_W-1:0]   rec_idx;
	logic [ENTRIES-1:0] rec_cand;
	logic               hit_d;
	logic               bump;
	logic               inval;
	logic               set_stamp;
	logic               set_key;
	logic [IDX_W-1:0]   w_idx;

	// take a new request only once the previous one has written back
	assign req_take = req_valid && !v_s2;
	assign done_s2  = v_s2 && !res_full;

	// stage 1: parallel key and stamp compare
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_d[i] = valid_q[i] && (key_q[i] == req.key);
			steq_d[i]  = (stamp_q[i] == req.stamp);
		end
	end

	// stage 1: least-age tree, lower index wins on ties
	always_comb begin
		take_r = 1'b0;
		for (int i = 0; i < NP; i++) begin
			t_age[NP+i]  = '1;
			t_idx[NP+i]  = IDX_W'(i);
			t_real[NP+i] = 1'b0;
			if (i < ENTRIES) begin
				t_age[NP+i]  = age_q[i];
				t_real[NP+i] = 1'b1;
			end
		end
		t_age[0]  = '1;
		t_idx[0]  = '0;
		t_real[0] = 1'b0;
		for (int k = NP - 1; k >= 1; k--) begin
			take_r = t_real[2*k+1] &&
				(!t_real[2*k] || (t_age[2*k+1] < t_age[2*k]));
			t_age[k]  = take_r ? t_age[2*k+1]  : t_age[2*k];
			t_idx[k]  = take_r ? t_idx[2*k+1]  : t_idx[2*k];
			t_real[k] = t_real[2*k] || t_real[2*k+1];
		end
	end

	// stage 2: first-match search and resolution
	assign rec_cand = match_s2 | inv_s2;

	always_comb begin
		lk_found  = 1'b0;
		lk_idx    = '0;
		rec_found = 1'b0;
		rec_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s2[i]) begin
				lk_found = 1'b1;
				lk_idx   = IDX_W'(i);
			end
			if (rec_cand[i]) begin
				rec_found = 1'b1;
				rec_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		hit_d     = 1'b0;
		bump      = 1'b0;
		inval     = 1'b0;
		set_stamp = 1'b0;
		set_key   = 1'b0;
		w_idx     = lk_idx;
		unique case (op_s2)
			OP_LOOKUP: begin
				if (lk_found) begin
					if (steq_s2[lk_idx]) begin
						hit_d = 1'b1;
						bump  = 1'b1;
					end else begin
						inval = 1'b1;
					end
				end
			end
			OP_RECORD: begin
				bump      = 1'b1;
				set_stamp = 1'b1;
				if (rec_found) begin
					w_idx   = rec_idx;
					set_key = inv_s2[rec_idx];
				end else begin
					w_idx   = lru_s2;
					set_key = 1'b1;
				end
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	assign res_full = (res_cnt_q == QDEPTH);
	assign empty    = (res_cnt_q == '0);
	assign hit      = res_q[res_rd_q];
	assign res_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			age_cnt_q <= '0;
			v_s2      <= 1'b0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (req_take) begin
				v_s2 <= 1'b1;
			end else if (done_s2) begin
				v_s2 <= 1'b0;
			end
			if (done_s2) begin
				if (bump) begin
					age_cnt_q <= age_cnt_q + 1'b1;
				end
				if (inval) begin
					valid_q[w_idx] <= 1'b0;
				end
				if (set_key) begin
					valid_q[w_idx] <= 1'b1;
				end
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			if (done_s2 && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !done_s2) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s2    <= req.op;
			key_s2   <= req.key;
			stamp_s2 <= req.stamp;
			match_s2 <= match_d;
			steq_s2  <= steq_d;
			inv_s2   <= ~valid_q;
			lru_s2   <= t_idx[1];
		end
		if (done_s2) begin
			res_q[res_wr_q] <= hit_d;
			if (bump) begin
				age_q[w_idx] <= age_cnt_q + 1'b1;
			end
			if (set_stamp) begin
				stamp_q[w_idx] <= stamp_s2;
			end
			if (set_key) begin
				key_q[w_idx] <= key_s2;
			end
		end
	end

endmodule

// ===== src/slpc_checker.sv =====
// ----------------------------------------------------------------------------
// slpc_checker
// Port-level checks of the poll cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "seq_tagged_lru_poll_cache_top_macros.svh"

module slpc_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic hit
);

	// queues come out of reset drained
	`SLPC_ASSERT_RST(a_reset_drained, !arst_n |-> (empty && !full), "queues not drained in reset")

	// the request queue fills only on an accepted request
	`SLPC_ASSERT(a_full_on_push, $rose(full) |-> $past(push && !full), "full rose without request")

	// a waiting result is not dropped or altered
	`SLPC_ASSERT(a_result_held, $past(!empty && !pop) |-> (!empty && $stable(hit)), "result lost")

	// the result queue drains only on a pop
	`SLPC_ASSERT(a_empty_on_pop, $rose(empty) |-> $past(pop), "empty rose without pop")

endmodule

bind seq_tagged_lru_poll_cache_top slpc_checker u_slpc_checker (.*);
